FILE: sv/mdb_pkg.sv
// Shared constants, types and register indexes for the multi-button debouncer.
`timescale 1ns / 1ps

package mdb_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int LANE_CAP = 8;
  localparam int NUM_LANES = (NUM_BUTTONS > LANE_CAP) ? LANE_CAP : NUM_BUTTONS;
  localparam int MASK_W = 8;
  localparam int RUN_W = 8;
  localparam int CFG_INDEX_W = 2;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};
  localparam logic [MASK_W-1:0] PULLUP_RESET = 8'hFF;
  localparam logic [RUN_W-1:0] SETTLE_RESET = 8'd4;

  localparam logic [CFG_INDEX_W-1:0] CFG_PULLUP_MASK = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_COUNT = 2'd1;

  typedef enum logic [1:0] {
    MODE_RELEASED = 2'd0,
    MODE_BOUNCING = 2'd1,
    MODE_PRESSED  = 2'd2
  } mode_t;

  typedef struct packed {
    logic pressed;
    logic bouncing;
  } lane_flags_t;

endpackage

FILE: sv/mdb_lane.sv
// One button lane: run counters and the released, bouncing and pressed state machine.
`timescale 1ns / 1ps

module mdb_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        level,
  input  logic                        pull_up,
  input  logic [mdb_pkg::RUN_W-1:0]   need,
  output mdb_pkg::lane_flags_t        flags
);
  import mdb_pkg::*;

  mode_t            mode;
  mode_t            mode_next;
  logic [RUN_W-1:0] high_run;
  logic [RUN_W-1:0] high_run_next;
  logic [RUN_W-1:0] low_run;
  logic [RUN_W-1:0] low_run_next;
  logic             active;

  assign active = pull_up ? !level : level;

  always_comb begin
    if (level) begin
      high_run_next = (high_run == RUN_MAX) ? high_run : high_run + 1'b1;
      low_run_next  = '0;
    end else begin
      low_run_next  = (low_run == RUN_MAX) ? low_run : low_run + 1'b1;
      high_run_next = '0;
    end

    case (mode)
      MODE_RELEASED: begin
        mode_next = active ? MODE_BOUNCING : MODE_RELEASED;
      end
      MODE_PRESSED: begin
        mode_next = active ? MODE_PRESSED : MODE_BOUNCING;
      end
      default: begin
        if (high_run_next >= need) begin
          mode_next = pull_up ? MODE_RELEASED : MODE_PRESSED;
        end else if (low_run_next >= need) begin
          mode_next = pull_up ? MODE_PRESSED : MODE_RELEASED;
        end else begin
          mode_next = MODE_BOUNCING;
        end
      end
    endcase

    flags.pressed  = (mode_next == MODE_PRESSED);
    flags.bouncing = (mode_next == MODE_BOUNCING);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_RELEASED;
      high_run <= '0;
      low_run  <= '0;
    end else if (accept) begin
      mode     <= mode_next;
      high_run <= high_run_next;
      low_run  <= low_run_next;
    end
  end

endmodule

FILE: sv/mdb_merge.sv
// Merging stage: packs the lane flags into masks and holds them in an output register with a skid.
`timescale 1ns / 1ps

module mdb_merge (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  mdb_pkg::lane_flags_t         flags [mdb_pkg::NUM_LANES],
  output logic                         skid_full,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mdb_pkg::MASK_W-1:0]   pressed_mask,
  output logic [mdb_pkg::MASK_W-1:0]   bouncing_mask
);
  import mdb_pkg::*;

  logic [MASK_W-1:0] new_pressed;
  logic [MASK_W-1:0] new_bouncing;
  logic [MASK_W-1:0] skid_pressed;
  logic [MASK_W-1:0] skid_bouncing;
  logic              skid_valid;
  logic              pop;

  always_comb begin
    new_pressed  = '0;
    new_bouncing = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      new_pressed[i]  = flags[i].pressed;
      new_bouncing[i] = flags[i].bouncing;
    end
  end

  assign pop       = out_valid && !out_stall;
  assign skid_full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        pressed_mask  <= skid_pressed;
        bouncing_mask <= skid_bouncing;
      end
    end else if (accept) begin
      if (out_valid && !pop) begin
        skid_pressed  <= new_pressed;
        skid_bouncing <= new_bouncing;
      end else begin
        pressed_mask  <= new_pressed;
        bouncing_mask <= new_bouncing;
      end
    end
  end

endmodule

FILE: sv/multi_button_debouncer.sv
// Top level of the multi-button debouncer: configuration registers, button lanes and merging stage.
//
//   channel  direction  handshake            word
//   in       to block   in_valid / in_stall  sample_levels
//   out      from block out_valid / out_stall pressed_mask, bouncing_mask
//   cfg      to block   cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each sample word's masks are loaded at the accepting edge into the output register, or into
// the skid register while the output register holds a stalled word; one word per cycle is
// sustained while the output is not stalled, set by the single register stage of the lanes.
// A synchronous reset releases every button, clears the run counters and restores the registers.
// When the output is stalled a second result waits in the skid register; in_stall rises only
// while that skid register is full. The configuration port is always ready.
`timescale 1ns / 1ps

module multi_button_debouncer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mdb_pkg::MASK_W-1:0]        sample_levels,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mdb_pkg::MASK_W-1:0]        pressed_mask,
  output logic [mdb_pkg::MASK_W-1:0]        bouncing_mask,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mdb_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mdb_pkg::RUN_W-1:0]         cfg_data
);
  import mdb_pkg::*;

  logic [MASK_W-1:0] pullup_mask;
  logic [RUN_W-1:0]  settle_count;
  logic [RUN_W-1:0]  need;
  logic              accept;
  logic              skid_full;
  lane_flags_t       flags [NUM_LANES];

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_full;
  assign accept    = in_valid && !in_stall;
  assign need      = (settle_count == '0) ? RUN_W'(1) : settle_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      pullup_mask  <= PULLUP_RESET;
      settle_count <= SETTLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PULLUP_MASK:  pullup_mask  <= cfg_data;
        CFG_SETTLE_COUNT: settle_count <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    mdb_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .accept  (accept),
      .level   (sample_levels[g]),
      .pull_up (pullup_mask[g]),
      .need    (need),
      .flags   (flags[g])
    );
  end

  mdb_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .flags         (flags),
    .skid_full     (skid_full),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pressed_mask  (pressed_mask),
    .bouncing_mask (bouncing_mask)
  );

endmodule

FILE: sv/mdb_checker.sv
// Port-level checks on the multi-button debouncer and the bind that attaches them.
`timescale 1ns / 1ps

module mdb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic [mdb_pkg::MASK_W-1:0]        pressed_mask,
  input logic [mdb_pkg::MASK_W-1:0]        bouncing_mask,
  input logic                              out_valid,
  input logic                              out_stall
);
  import mdb_pkg::*;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid && !in_stall)
    else $error("Output or skid word present straight after reset.");

  a_stall_needs_output: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("Input stalled while the output register is empty.");

  a_accept_gives_word: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("Accepted sample word produced no result word.");

  a_masks_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pressed_mask & bouncing_mask) == '0)
    else $error("A button is reported both pressed and bouncing.");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(pressed_mask)
      && $stable(bouncing_mask))
    else $error("Stalled result word changed or vanished.");

endmodule

bind multi_button_debouncer mdb_checker u_mdb_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .pressed_mask  (pressed_mask),
  .bouncing_mask (bouncing_mask),
  .out_valid     (out_valid),
  .out_stall     (out_stall)
);

FILE: dv/tb_multi_button_debouncer.sv
// Self-checking testbench for the multi-button debouncer: directed table, random phases and scoreboard.
`timescale 1ns / 1ps

module tb_multi_button_debouncer;
  import mdb_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int ITEM_TARGET = 1200;
  localparam int NUM_DIRECTED = 24;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] bouncing;
  } masks_t;

  typedef enum bit {ROW_SAMPLE, ROW_CONFIG} row_kind_e;
  typedef enum int {STYLE_HOLD, STYLE_NOISE, STYLE_CHATTER} phase_style_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_INDEX_W-1:0]   index;
    logic [MASK_W-1:0]        value;
    bit                       typed;
    logic [MASK_W-1:0]        pressed;
    logic [MASK_W-1:0]        bouncing;
  } stim_row_t;

  // Rows marked typed carry masks that follow directly from the reset state.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'hFF, 1'b1, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h00, 1'b1, 8'h00, 8'hFF},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h00, 1'b1, 8'h00, 8'hFF},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h00, 1'b1, 8'h00, 8'hFF},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h00, 1'b1, 8'hFF, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'hFF, 1'b1, 8'h00, 8'hFF},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h5A, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'hA5, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_PULLUP_MASK,  8'h00, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_SETTLE_COUNT, 8'h01, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h0F, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'hF0, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'hF0, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_SETTLE_COUNT, 8'h00, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h33, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'hCC, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_SPARE_A,      8'hAA, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_SPARE_B,      8'h55, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_PULLUP_MASK,  8'hA5, 1'b0, 8'h00, 8'h00},
    '{ROW_CONFIG, CFG_SETTLE_COUNT, 8'h02, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h81, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h7E, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h7E, 1'b0, 8'h00, 8'h00},
    '{ROW_SAMPLE, CFG_PULLUP_MASK,  8'h00, 1'b0, 8'h00, 8'h00}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [MASK_W-1:0]      sample_levels = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MASK_W-1:0]      pressed_mask;
  logic [MASK_W-1:0]      bouncing_mask;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [RUN_W-1:0]       cfg_data = '0;

  logic [MASK_W-1:0] pull_cfg;
  logic [RUN_W-1:0]  settle_cfg;
  mode_t             lane_mode [NUM_LANES];
  logic [RUN_W-1:0]  hi_run [NUM_LANES];
  logic [RUN_W-1:0]  lo_run [NUM_LANES];

  masks_t pending_masks [$];
  int     mismatches = 0;
  int     words_sent = 0;
  int     pressed_words = 0;
  int     bouncing_words = 0;
  int     cfg_writes = 0;
  int     idle_cycles = 0;
  int     stall_left = 0;
  bit     quiet_in = 1'b0;
  bit     quiet_out = 1'b0;

  multi_button_debouncer dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .sample_levels (sample_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pressed_mask  (pressed_mask),
    .bouncing_mask (bouncing_mask),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic masks_t debounce_tick(input logic [MASK_W-1:0] levels);
    masks_t           res;
    logic [RUN_W-1:0] need;
    logic             lvl;
    logic             pu;
    logic             act;
    mode_t            m;
    res = '0;
    need = (settle_cfg == '0) ? RUN_W'(1) : settle_cfg;
    for (int i = 0; i < NUM_LANES; i++) begin
      lvl = levels[i];
      pu = pull_cfg[i];
      act = pu ? !lvl : lvl;
      if (lvl) begin
        if (hi_run[i] != RUN_MAX) hi_run[i] = hi_run[i] + 1'b1;
        lo_run[i] = '0;
      end else begin
        if (lo_run[i] != RUN_MAX) lo_run[i] = lo_run[i] + 1'b1;
        hi_run[i] = '0;
      end
      m = lane_mode[i];
      case (m)
        MODE_RELEASED: if (act) m = MODE_BOUNCING;
        MODE_PRESSED: if (!act) m = MODE_BOUNCING;
        default: begin
          if (hi_run[i] >= need) m = pu ? MODE_RELEASED : MODE_PRESSED;
          else if (lo_run[i] >= need) m = pu ? MODE_PRESSED : MODE_RELEASED;
          else m = MODE_BOUNCING;
        end
      endcase
      lane_mode[i] = m;
      if (m == MODE_PRESSED) res.pressed[i] = 1'b1;
      else if (m == MODE_BOUNCING) res.bouncing[i] = 1'b1;
    end
    return res;
  endfunction

  task automatic send_sample(input logic [MASK_W-1:0] levels, input bit typed,
                             input masks_t typed_masks);
    int     gap;
    masks_t predicted;
    gap = quiet_in ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_levels <= levels;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = debounce_tick(levels);
    pending_masks.push_back(typed ? typed_masks : predicted);
    words_sent++;
    if (predicted.pressed != '0) pressed_words++;
    if (predicted.bouncing != '0) bouncing_words++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
  endtask

  // The caller lowers cfg_valid once a batch of writes is done.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [RUN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_PULLUP_MASK: pull_cfg = value;
      CFG_SETTLE_COUNT: settle_cfg = value;
      default: ;
    endcase
    cfg_writes++;
  endtask

  always @(posedge clk) begin : out_pacing
    int hold;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold = quiet_out ? 0 : $urandom_range(0, 19);
      stall_left <= hold;
      out_stall <= (hold != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left != 1);
    end
  end

  always @(posedge clk) begin : result_check
    masks_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_masks.size() == 0) begin
        $display("%0t: unexpected word, pressed_mask %02h bouncing_mask %02h",
                 $time, pressed_mask, bouncing_mask);
        mismatches++;
      end else begin
        want = pending_masks.pop_front();
        if (pressed_mask !== want.pressed) begin
          $display("%0t: pressed_mask expected %02h actual %02h",
                   $time, want.pressed, pressed_mask);
          mismatches++;
        end
        if (bouncing_mask !== want.bouncing) begin
          $display("%0t: bouncing_mask expected %02h actual %02h",
                   $time, want.bouncing, bouncing_mask);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t         row;
    masks_t            typed_m;
    phase_style_e      style;
    logic [MASK_W-1:0] levels;
    logic [MASK_W-1:0] hold_level;
    logic [MASK_W-1:0] target;
    logic [MASK_W-1:0] new_pull;
    logic [RUN_W-1:0]  new_settle;
    int                chatter [NUM_LANES];
    int                phase_len;
    int                phases;
    int                random_items;
    int                b;

    pull_cfg = PULLUP_RESET;
    settle_cfg = SETTLE_RESET;
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_mode[i] = MODE_RELEASED;
      hi_run[i] = '0;
      lo_run[i] = '0;
      chatter[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < NUM_DIRECTED; r++) begin
      row = DIRECTED_ROWS[r];
      if (row.kind == ROW_CONFIG) begin
        wait_idle();
        cfg_write(row.index, row.value);
        if (r + 1 == NUM_DIRECTED || DIRECTED_ROWS[r + 1].kind != ROW_CONFIG)
          cfg_valid <= 1'b0;
      end else begin
        typed_m.pressed = row.pressed;
        typed_m.bouncing = row.bouncing;
        send_sample(row.value, row.typed, typed_m);
      end
    end

    // The opening phases hold one level long enough to saturate the runs, then flip the
    // polarity so that a saturated run has to settle the button at once.
    phases = 0;
    random_items = 0;
    new_pull = '0;
    while (random_items < ITEM_TARGET) begin
      wait_idle();
      if (phases == 0) begin
        new_pull = MASK_W'($urandom_range(0, 255));
        new_settle = RUN_MAX;
        style = STYLE_HOLD;
      end else if (phases == 1) begin
        new_pull = ~new_pull;
        new_settle = RUN_MAX;
        style = STYLE_CHATTER;
      end else begin
        case ($urandom_range(0, 3))
          0: new_pull = '0;
          1: new_pull = '1;
          default: new_pull = MASK_W'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 9))
          0: new_settle = '0;
          1: new_settle = RUN_W'(1);
          2: new_settle = RUN_MAX;
          3: new_settle = RUN_W'($urandom_range(1, 255));
          default: new_settle = RUN_W'($urandom_range(2, 6));
        endcase
        case ($urandom_range(0, 9))
          0: style = STYLE_HOLD;
          1, 2: style = STYLE_NOISE;
          default: style = STYLE_CHATTER;
        endcase
      end
      if ($urandom_range(0, 3) == 0)
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                  RUN_W'($urandom_range(0, 255)));
      cfg_write(CFG_PULLUP_MASK, new_pull);
      cfg_write(CFG_SETTLE_COUNT, new_settle);
      cfg_valid <= 1'b0;

      quiet_in = ($urandom_range(0, 3) == 0);
      quiet_out = ($urandom_range(0, 3) == 0);
      case (style)
        STYLE_HOLD: phase_len = (phases == 0) ? 300 : $urandom_range(260, 300);
        STYLE_NOISE: phase_len = $urandom_range(10, 30);
        default: phase_len = $urandom_range(40, 90);
      endcase
      hold_level = MASK_W'($urandom_range(0, 255));
      target = MASK_W'($urandom_range(0, 255));

      for (int k = 0; k < phase_len; k++) begin
        case (style)
          STYLE_HOLD: levels = hold_level;
          STYLE_NOISE: levels = MASK_W'($urandom_range(0, 255));
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              b = $urandom_range(0, NUM_LANES - 1);
              target[b] = !target[b];
              chatter[b] = $urandom_range(0, 6);
            end
            levels = MASK_W'($urandom_range(0, 255));
            for (int i = 0; i < NUM_LANES; i++) begin
              if (chatter[i] != 0) begin
                levels[i] = 1'($urandom_range(0, 1));
                chatter[i]--;
              end else begin
                levels[i] = target[i];
              end
            end
          end
        endcase
        send_sample(levels, 1'b0, '0);
        random_items++;
      end
      phases++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_masks.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, pending_masks.size());
      mismatches++;
    end
    $display("Drove %0d sample words over %0d random phases with %0d register writes.",
             words_sent, phases, cfg_writes);
    $display("%0d words reported a pressed button and %0d a bouncing one; %0d mismatches.",
             pressed_words, bouncing_words, mismatches);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
